// ===== src/pnr_pkg.sv =====
`default_nettype none

package pnr_pkg;

   // Fixed field widths
   localparam int MAX_DIM     = 4096;
   localparam int DIM_W       = 13;
   localparam int COORD_W     = 14;
   localparam int DELTA_W     = 15;
   localparam int EDGE_W      = 32;
   localparam int PIX_W       = 12;
   localparam int COLOR_W     = 32;
   localparam int EDGE_IDX_W  = 2;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 13;

   localparam logic [DIM_W-1:0] FB_WIDTH_RESET  = 13'd640;
   localparam logic [DIM_W-1:0] FB_HEIGHT_RESET = 13'd480;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FB_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FB_HEIGHT = 1'b1;

   // Request types
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_STEP = 1'b1;

   // Last edge of the setup sequence
   localparam logic [EDGE_IDX_W-1:0] EDGE_LAST = 2'd2;

   typedef struct packed {
      logic                      req_type;
      logic signed [COORD_W-1:0] v1_x;
      logic signed [COORD_W-1:0] v1_y;
      logic signed [COORD_W-1:0] v2_x;
      logic signed [COORD_W-1:0] v2_y;
      logic signed [COORD_W-1:0] v3_x;
      logic signed [COORD_W-1:0] v3_y;
      logic [COLOR_W-1:0]        fill_color;
   } req_word_type;

   typedef struct packed {
      logic [PIX_W-1:0]   pixel_x;
      logic [PIX_W-1:0]   pixel_y;
      logic               pixel_valid;
      logic               covered;
      logic [COLOR_W-1:0] pixel_color;
      logic               last;
   } rsp_word_type;

   // Controller to datapath
   typedef struct packed {
      logic                  capture;
      logic                  box;
      logic                  mul;
      logic                  acc;
      logic                  step;
      logic                  push_load;
      logic [EDGE_IDX_W-1:0] edge_idx;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic box_empty;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

// ===== src/pnr_if.sv =====
`default_nettype none

interface pnr_req_if;
   import pnr_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      req_type;
   logic signed [COORD_W-1:0] v1_x;
   logic signed [COORD_W-1:0] v1_y;
   logic signed [COORD_W-1:0] v2_x;
   logic signed [COORD_W-1:0] v2_y;
   logic signed [COORD_W-1:0] v3_x;
   logic signed [COORD_W-1:0] v3_y;
   logic [COLOR_W-1:0]        fill_color;

   modport source (
      output valid, req_type, v1_x, v1_y, v2_x, v2_y, v3_x, v3_y, fill_color,
      input  ready
   );

   modport sink (
      input  valid, req_type, v1_x, v1_y, v2_x, v2_y, v3_x, v3_y, fill_color,
      output ready
   );
endinterface

interface pnr_rsp_if;
   import pnr_pkg::*;

   logic               valid;
   logic               ready;
   logic [PIX_W-1:0]   pixel_x;
   logic [PIX_W-1:0]   pixel_y;
   logic               pixel_valid;
   logic               covered;
   logic [COLOR_W-1:0] pixel_color;
   logic               last;

   modport source (
      output valid, pixel_x, pixel_y, pixel_valid, covered, pixel_color, last,
      input  ready
   );

   modport sink (
      input  valid, pixel_x, pixel_y, pixel_valid, covered, pixel_color, last,
      output ready
   );
endinterface

`default_nettype wire

// ===== src/pnr_ctrl.sv =====
`default_nettype none

module pnr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_type,
   input  pnr_pkg::status_type status,
   output logic                req_ready,
   output pnr_pkg::cmd_type    cmd
);
   import pnr_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BOX,
      ST_MUL,
      ST_ACC,
      ST_DONE
   } state_type;

   state_type             state_ff;
   logic [EDGE_IDX_W-1:0] edge_ff;
   logic                  req_fire;

   assign req_fire = (state_ff == ST_IDLE) && req_valid && status.out_free;

   always_comb begin
      cmd          = '0;
      cmd.edge_idx = edge_ff;
      req_ready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = status.out_free;
            cmd.capture = req_fire && (req_type == REQ_LOAD);
            cmd.step    = req_fire && (req_type == REQ_STEP);
         end
         ST_BOX:  cmd.box       = 1'b1;
         ST_MUL:  cmd.mul       = !status.box_empty;
         ST_ACC:  cmd.acc       = 1'b1;
         ST_DONE: cmd.push_load = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         edge_ff  <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_fire && (req_type == REQ_LOAD)) state_ff <= ST_BOX;
            end
            ST_BOX: begin
               edge_ff  <= '0;
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               if (status.box_empty) state_ff <= ST_DONE;
               else                  state_ff <= ST_ACC;
            end
            ST_ACC: begin
               if (edge_ff == EDGE_LAST) begin
                  state_ff <= ST_DONE;
               end else begin
                  edge_ff  <= edge_ff + 1'b1;
                  state_ff <= ST_MUL;
               end
            end
            ST_DONE: state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

`ifndef SYNTH
   // A load result must never overwrite a word still waiting at the output
   a_load_push_free: assert property (@(posedge clock) disable iff (reset)
      cmd.push_load |-> status.out_free)
      else $error("load result pushed into a full output register");

   // Accumulate always follows the multiply of the same edge
   a_acc_after_mul: assert property (@(posedge clock) disable iff (reset)
      cmd.acc |-> ($past(cmd.mul) && ($past(cmd.edge_idx) == cmd.edge_idx)))
      else $error("accumulate without matching multiply");

   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.box, cmd.mul, cmd.acc, cmd.step, cmd.push_load}))
      else $error("more than one datapath command at once");
`endif

endmodule

`default_nettype wire

// ===== src/pnr_datapath.sv =====
`default_nettype none

module pnr_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  pnr_pkg::cmd_type                     cmd,
   input  pnr_pkg::req_word_type                req_word,
   input  logic                                 csr_write_en,
   input  logic [pnr_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [pnr_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output pnr_pkg::rsp_word_type                rsp_word,
   output pnr_pkg::status_type                  status
);
   import pnr_pkg::*;

   localparam int PROD_W = 31;
   localparam logic [DIM_W-1:0] MAX_DIM_V = DIM_W'(MAX_DIM);

   function automatic logic [EDGE_IDX_W-1:0] next_vertex(input logic [EDGE_IDX_W-1:0] k);
      logic [EDGE_IDX_W-1:0] j;
      case (k)
         2'd0:    j = 2'd1;
         2'd1:    j = 2'd2;
         default: j = 2'd0;
      endcase
      return j;
   endfunction

   function automatic logic signed [COORD_W-1:0] min3(
      input logic signed [COORD_W-1:0] a,
      input logic signed [COORD_W-1:0] b,
      input logic signed [COORD_W-1:0] c);
      logic signed [COORD_W-1:0] r;
      r = (a < b) ? a : b;
      return (r < c) ? r : c;
   endfunction

   function automatic logic signed [COORD_W-1:0] max3(
      input logic signed [COORD_W-1:0] a,
      input logic signed [COORD_W-1:0] b,
      input logic signed [COORD_W-1:0] c);
      logic signed [COORD_W-1:0] r;
      r = (a > b) ? a : b;
      return (r > c) ? r : c;
   endfunction

   // Configuration
   logic [DIM_W-1:0] fb_width_ff, fb_height_ff;

   // Captured triangle
   logic signed [COORD_W-1:0] vx_ff [3];
   logic signed [COORD_W-1:0] vy_ff [3];
   logic [COLOR_W-1:0]        held_color_ff;

   // Box and walk state
   logic [DIM_W-1:0] box_left_ff, box_right_ff, box_bottom_ff;
   logic [DIM_W-1:0] cursor_x_ff, cursor_y_ff;
   logic             box_empty_ff;
   logic             active_ff;

   // Edge functions
   logic signed [DELTA_W-1:0] step_x_ff [3];
   logic signed [DELTA_W-1:0] step_y_ff [3];
   logic signed [EDGE_W-1:0]  edge_ff    [3];
   logic signed [EDGE_W-1:0]  row_adv_ff [3];

   // Setup products
   logic signed [EDGE_W-1:0] prod_a_ff, prod_b_ff, prod_c_ff;

   // Output register
   logic         rsp_valid_ff;
   rsp_word_type rsp_word_ff;

   // ---------------- bounding box ----------------
   logic [DIM_W-1:0]          w_sat, h_sat;
   logic signed [COORD_W-1:0] min_x, max_x, min_y, max_y;
   logic [DIM_W-1:0]          lo_x, lo_y;
   logic signed [DELTA_W-1:0] lo_x_s, lo_y_s, hi_x_s, hi_y_s, w_s, h_s, max_x_s, max_y_s;
   logic                      empty_in;

   always_comb begin
      w_sat   = (fb_width_ff  > MAX_DIM_V) ? MAX_DIM_V : fb_width_ff;
      h_sat   = (fb_height_ff > MAX_DIM_V) ? MAX_DIM_V : fb_height_ff;
      min_x   = min3(vx_ff[0], vx_ff[1], vx_ff[2]);
      max_x   = max3(vx_ff[0], vx_ff[1], vx_ff[2]);
      min_y   = min3(vy_ff[0], vy_ff[1], vy_ff[2]);
      max_y   = max3(vy_ff[0], vy_ff[1], vy_ff[2]);
      lo_x    = min_x[COORD_W-1] ? '0 : DIM_W'(min_x[COORD_W-2:0]);
      lo_y    = min_y[COORD_W-1] ? '0 : DIM_W'(min_y[COORD_W-2:0]);
      lo_x_s  = $signed({2'b00, lo_x});
      lo_y_s  = $signed({2'b00, lo_y});
      w_s     = $signed({2'b00, w_sat});
      h_s     = $signed({2'b00, h_sat});
      max_x_s = DELTA_W'(max_x);
      max_y_s = DELTA_W'(max_y);
      hi_x_s  = (max_x_s > w_s) ? w_s : max_x_s;
      hi_y_s  = (max_y_s > h_s) ? h_s : max_y_s;
      empty_in = (lo_x_s >= hi_x_s) || (lo_y_s >= hi_y_s);
   end

   // ---------------- setup multiplies ----------------
   logic [EDGE_IDX_W-1:0]     k_sel, j_sel;
   logic signed [15:0]        diff_x, diff_y;
   logic [DIM_W-1:0]          box_w;
   logic signed [PROD_W-1:0]  mul_a, mul_b, mul_c;

   always_comb begin
      k_sel  = cmd.edge_idx;
      j_sel  = next_vertex(k_sel);
      diff_x = $signed({3'b000, box_left_ff}) - 16'(vx_ff[j_sel]);
      diff_y = $signed({3'b000, cursor_y_ff}) - 16'(vy_ff[j_sel]);
      box_w  = box_right_ff - box_left_ff;
      mul_a  = PROD_W'(diff_x) * PROD_W'(step_x_ff[k_sel]);
      mul_b  = PROD_W'(diff_y) * PROD_W'(step_y_ff[k_sel]);
      mul_c  = PROD_W'($signed({1'b0, box_w})) * PROD_W'(step_x_ff[k_sel]);
   end

   // ---------------- pixel step ----------------
   logic         cov, row_end, fin;
   logic [DIM_W:0] cx_next, cy_next;
   rsp_word_type step_word, load_word;

   always_comb begin
      cov     = !edge_ff[0][EDGE_W-1] && !edge_ff[1][EDGE_W-1] && !edge_ff[2][EDGE_W-1];
      cx_next = {1'b0, cursor_x_ff} + 1'b1;
      cy_next = {1'b0, cursor_y_ff} + 1'b1;
      row_end = cx_next >= {1'b0, box_right_ff};
      fin     = row_end && (cy_next >= {1'b0, box_bottom_ff});

      step_word = '0;
      if (active_ff) begin
         step_word.pixel_x     = cursor_x_ff[PIX_W-1:0];
         step_word.pixel_y     = cursor_y_ff[PIX_W-1:0];
         step_word.pixel_valid = 1'b1;
         step_word.covered     = cov;
         step_word.pixel_color = cov ? held_color_ff : '0;
         step_word.last        = fin;
      end

      load_word      = '0;
      load_word.last = box_empty_ff;
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         fb_width_ff  <= FB_WIDTH_RESET;
         fb_height_ff <= FB_HEIGHT_RESET;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_FB_WIDTH:  fb_width_ff  <= csr_wdata;
               CSR_FB_HEIGHT: fb_height_ff <= csr_wdata;
               default: ;
            endcase
         end

         if (cmd.box)                       active_ff <= !empty_in;
         else if (cmd.step && active_ff && fin) active_ff <= 1'b0;

         if (cmd.step || cmd.push_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready)            rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         vx_ff[0]      <= req_word.v1_x;
         vy_ff[0]      <= req_word.v1_y;
         vx_ff[1]      <= req_word.v2_x;
         vy_ff[1]      <= req_word.v2_y;
         vx_ff[2]      <= req_word.v3_x;
         vy_ff[2]      <= req_word.v3_y;
         held_color_ff <= req_word.fill_color;
      end

      if (cmd.box) begin
         box_empty_ff  <= empty_in;
         box_left_ff   <= lo_x;
         box_right_ff  <= hi_x_s[DIM_W-1:0];
         box_bottom_ff <= hi_y_s[DIM_W-1:0];
         cursor_x_ff   <= lo_x;
         cursor_y_ff   <= lo_y;
         for (int k = 0; k < 3; k++) begin
            // step_x is minus dy of the edge, step_y is dx
            step_x_ff[k] <= DELTA_W'(vy_ff[k]) - DELTA_W'(vy_ff[next_vertex(2'(k))]);
            step_y_ff[k] <= DELTA_W'(vx_ff[next_vertex(2'(k))]) - DELTA_W'(vx_ff[k]);
         end
      end

      if (cmd.mul) begin
         prod_a_ff <= EDGE_W'(mul_a);
         prod_b_ff <= EDGE_W'(mul_b);
         prod_c_ff <= EDGE_W'(mul_c);
      end

      if (cmd.acc) begin
         edge_ff[k_sel]    <= prod_a_ff + prod_b_ff;
         row_adv_ff[k_sel] <= EDGE_W'(step_x_ff[k_sel]) + EDGE_W'(step_y_ff[k_sel]) - prod_c_ff;
      end

      if (cmd.step && active_ff) begin
         for (int k = 0; k < 3; k++) begin
            edge_ff[k] <= edge_ff[k] + (row_end ? row_adv_ff[k] : EDGE_W'(step_x_ff[k]));
         end
         if (row_end) begin
            cursor_x_ff <= box_left_ff;
            cursor_y_ff <= cy_next[DIM_W-1:0];
         end else begin
            cursor_x_ff <= cx_next[DIM_W-1:0];
         end
      end

      if (cmd.step)           rsp_word_ff <= step_word;
      else if (cmd.push_load) rsp_word_ff <= load_word;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_word         = rsp_word_ff;
   assign status.box_empty = box_empty_ff;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

`ifndef SYNTH
   // Walk ends only on a final-pixel step or a new load
   a_active_drop: assert property (@(posedge clock) disable iff (reset)
      $fell(active_ff) |-> $past(cmd.step || cmd.box))
      else $error("active dropped without a step or load");

   a_box_active: assert property (@(posedge clock) disable iff (reset)
      cmd.box |=> (active_ff == !box_empty_ff))
      else $error("active does not match box emptiness after setup");

   a_cov_pixel: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_word_ff.covered) |-> rsp_word_ff.pixel_valid)
      else $error("covered word without a visited pixel");
`endif

endmodule

`default_nettype wire

// ===== src/pineda_triangle_rasterizer.sv =====
`default_nettype none

// Edge-function triangle rasterizer. A load word (req_type 0) clips the bounding box of
// three vertices to the framebuffer window, sets up an edge function per side and answers
// with one word whose last flag is set when the clipped box is empty. Each step word
// (req_type 1) then visits the next pixel of the box in row-major order and answers with
// its coordinates, a coverage flag (every edge value nonnegative, one winding only),
// the fill color when covered and last on the final pixel; a step with no triangle loaded
// answers with an all-zero word, as does a step after the final pixel. Every request gives
// exactly one response. Timing: a step's response is registered in the cycle after the
// step is accepted, so steps stream at one pixel per clock while rsp_bus.ready stays high.
// A load keeps the request side busy through the box clip, a multiply and an accumulate
// state per edge on the shared setup multipliers, then the response push; an empty clipped
// box skips from multiply to push. fb_width (index 0) and fb_height (index 1) saturate to
// 4096; the user must write them via the csr port only while the block is idle, unchecked.
module pineda_triangle_rasterizer (
   input  logic                             clock,
   input  logic                             reset,
   pnr_req_if.sink                          req_bus,
   pnr_rsp_if.source                        rsp_bus,
   input  logic                             csr_write_en,
   input  logic [pnr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pnr_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import pnr_pkg::*;

   cmd_type      cmd;
   status_type   status;
   req_word_type req_word;
   rsp_word_type rsp_word;
   logic         rsp_valid;

   // Gather the request payload into one word for the datapath
   assign req_word.req_type   = req_bus.req_type;
   assign req_word.v1_x       = req_bus.v1_x;
   assign req_word.v1_y       = req_bus.v1_y;
   assign req_word.v2_x       = req_bus.v2_x;
   assign req_word.v2_y       = req_bus.v2_y;
   assign req_word.v3_x       = req_bus.v3_x;
   assign req_word.v3_y       = req_bus.v3_y;
   assign req_word.fill_color = req_bus.fill_color;

   // Sequencer: accepts words, runs the load setup, issues steps
   pnr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_type  (req_bus.req_type),
      .status    (status),
      .req_ready (req_bus.ready),
      .cmd       (cmd)
   );

   // Box clip, edge setup, pixel walk and the output register
   pnr_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .req_word     (req_word),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .rsp_ready    (rsp_bus.ready),
      .rsp_valid    (rsp_valid),
      .rsp_word     (rsp_word),
      .status       (status)
   );

   // Drive the response channel straight from the output register
   assign rsp_bus.valid       = rsp_valid;
   assign rsp_bus.pixel_x     = rsp_word.pixel_x;
   assign rsp_bus.pixel_y     = rsp_word.pixel_y;
   assign rsp_bus.pixel_valid = rsp_word.pixel_valid;
   assign rsp_bus.covered     = rsp_word.covered;
   assign rsp_bus.pixel_color = rsp_word.pixel_color;
   assign rsp_bus.last        = rsp_word.last;

endmodule

`default_nettype wire
